// ===== rtl/core/ddf_pkg.sv =====
// ddf_pkg: shared constants, codes and fixed-point helpers for the dust
// diffusion flux pipeline. No dependencies; ddf_delay and ddf_result_if skip it.
package ddf_pkg;

  // fixed-point format: unsigned magnitudes of QW bits, FRAC_BITS fraction bits
  localparam int QW        = 31;
  localparam int FRAC_BITS = 24;

  localparam logic [QW-1:0] MAXQ   = {QW{1'b1}};
  localparam logic [63:0]   MAXQ64 = 64'(MAXQ);
  localparam logic [63:0]   ONE64  = 64'd1 << FRAC_BITS;

  // sqrt(pi/8) with 40 fraction bits, cut down to the working format
  localparam logic [63:0]   SQRT_PI_8_Q40 = 64'd689016733616;
  localparam logic [63:0]   KQ_RAW = SQRT_PI_8_Q40 >> (40 - FRAC_BITS);
  localparam logic          KQ_SAT = KQ_RAW > MAXQ64;
  localparam logic [QW-1:0] KQ     = KQ_SAT ? MAXQ : KQ_RAW[QW-1:0];

  // square root of one Q value: radicand shift kept to at most 32 bits
  localparam int QS_E  = (FRAC_BITS > 32) ? (((FRAC_BITS - 32) + 1) / 2) * 2 : 0;
  localparam int QS_SH = FRAC_BITS - QS_E;
  localparam int QS_UP = QS_E / 2;

  // latency of the shared arithmetic units, in registers
  localparam int LAT_DIV  = QW + 1;
  localparam int SQW      = 32;
  localparam int LAT_SQRT = SQW;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEOMETRY  = 3'd0,
    REG_CONST_ST  = 3'd1,
    REG_VISCOSITY = 3'd2,
    REG_STOKES    = 3'd3,
    REG_DUST_SIZE = 3'd4,
    REG_ASPECT    = 3'd5,
    REG_TIME_STEP = 3'd6,
    REG_RADIUS    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GEO_CARTESIAN   = 2'd0,
    GEO_RADIAL      = 2'd1,
    GEO_AZIMUTHAL   = 2'd2,
    GEO_COLATITUDE  = 2'd3
  } geo_t;

  // saturating result: magnitude plus overflow mark
  typedef struct packed {
    logic          sat;
    logic [QW-1:0] val;
  } qres_t;

  // clamp a wide magnitude to the Q range
  function automatic qres_t qclamp(logic [63:0] x);
    qres_t r;
    r.sat = x > MAXQ64;
    r.val = r.sat ? MAXQ : x[QW-1:0];
    return r;
  endfunction

  // (a * b) >> FRAC_BITS, truncated and clamped
  function automatic qres_t qmul(logic [QW-1:0] a, logic [QW-1:0] b);
    logic [63:0] p;
    p = ({{(64-QW){1'b0}}, a} * {{(64-QW){1'b0}}, b}) >> FRAC_BITS;
    return qclamp(p);
  endfunction

endpackage

// ===== rtl/core/ddf_feed_if.sv =====
// ddf_feed_if: input channel of the dust diffusion flux block, one
// interface per item. Depends on ddf_pkg for field widths.
interface ddf_feed_if;
  logic                        valid;
  logic                        ready;
  logic [ddf_pkg::QW-1:0]      dust_left;
  logic [ddf_pkg::QW-1:0]      dust_right;
  logic [ddf_pkg::QW-1:0]      gas_left;
  logic [ddf_pkg::QW-1:0]      gas_right;
  logic signed [31:0]          center_here;
  logic signed [31:0]          center_before;
  logic [ddf_pkg::QW-1:0]      sound_before;
  logic [ddf_pkg::QW-1:0]      sound_here;
  logic [ddf_pkg::QW-1:0]      surface;

  modport source (
    output valid, dust_left, dust_right, gas_left, gas_right, center_here,
           center_before, sound_before, sound_here, surface,
    input  ready
  );
  modport sink (
    input  valid, dust_left, dust_right, gas_left, gas_right, center_here,
           center_before, sound_before, sound_here, surface,
    output ready
  );
endinterface

// ===== rtl/core/ddf_result_if.sv =====
// ddf_result_if: output channel of the dust diffusion flux block.
// Depends on nothing beyond plain logic types.
interface ddf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] diffusion_flux;
  logic               saturated;

  modport source (output valid, diffusion_flux, saturated, input ready);
  modport sink (input valid, diffusion_flux, saturated, output ready);
endinterface

// ===== rtl/core/dust_diffusion_flux.sv =====
// dust_diffusion_flux: dust mass diffusion flux across one cell interface.
// Depends on ddf_pkg, ddf_feed_if, ddf_result_if, ddf_delay, ddf_div, ddf_sqrt.
//
// Usage:
//   feed carries one interface per item (densities, cell centers, sound
//   speeds, surface); result returns one item per feed item, in order, with
//   the signed Q8.24 flux and a saturation mark. Both use valid/ready.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data,
//   one register per cycle; the user must write only with no item in flight (not enforced).
//   Pipeline: the input register loads at the accepting edge, then come 203
//   pipeline stages and the output register. The chain is set by six
//   pipelined dividers of 32 stages each plus the multiply stages between them.
//   Throughput: one item per cycle while the pipeline is not held by a stall.
//   Stall: the whole pipeline holds when its last stage has an item and the
//   output register is full and not taken; otherwise items keep entering,
//   so bubbles are squeezed out behind a waiting result.
//   Reset (rst, synchronous): all valid bits clear, registers return to
//   their defaults (aspect ratio and radius 1.0, fixed Stokes mode).
module dust_diffusion_flux (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ddf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddf_pkg::CFG_DATA_W-1:0] cfg_data,
  ddf_feed_if.sink                       feed,
  ddf_result_if.source                   result
);
  import ddf_pkg::*;

  localparam int LAT = 6 * LAT_DIV + 12;

  typedef struct packed {
    logic          dxneg;
    logic          chpos;
    logic          neg;
    logic          flag;
    logic          rflag;
    logic [31:0]   adx;
    logic [QW-1:0] r;
    logic [QW-1:0] surf;
    logic [QW-1:0] rr2;
    logic [QW-1:0] r3;
    logic [QW-1:0] num1;
    logic [QW-1:0] adiff;
    logic [QW-1:0] g;
    logic [QW-1:0] cap;
    logic [QW-1:0] den1;
    logic [QW-1:0] den;
    logic [QW-1:0] sqc;
    logic [QW-1:0] num;
    logic [QW-1:0] st2;
    logic [QW-1:0] dden;
    logic [QW-1:0] dg;
    logic [QW-1:0] dga;
    logic [QW-1:0] lim;
    logic [QW-1:0] m1;
    logic [QW-1:0] m2;
  } side_t;

  // configuration registers
  geo_t          geometry_direction;
  logic          constant_stokes;
  logic [QW-1:0] viscosity;
  logic [QW-1:0] stokes_number;
  logic [QW-1:0] dust_size;
  logic [QW-1:0] aspect_ratio;
  logic [QW-1:0] time_step;
  logic [QW-1:0] beam_radius;
  logic          dir13;
  logic          derived;

  // flow control
  logic [LAT-1:0] vld;
  logic           en;
  logic           out_valid;
  logic signed [31:0] out_flux;
  logic           out_sat;

  // input register
  logic [QW-1:0]      i_dl, i_dr, i_gl, i_gr, i_sb, i_sh, i_surf;
  logic signed [31:0] i_ch, i_cb;

  // stage records
  side_t s1, s1_next, s2, s2_next, s32, s33, s33_next, s34, s34_next;
  side_t s35, s35_next, s67, s68, s68_next, s100, s101, s101_next;
  side_t s102, s102_next, s134, s135, s135_next, s136, s136_next;
  side_t s168, s169, s169_next, s201, s202, s202_next, s203, s203_next;

  logic [63:0] p_g, p_s, p_d;

  // unit outputs
  logic [QW-1:0]  rl_q, rr_q, om_q, st_q, d_q, mag_q, az_q;
  logic           rl_ovf, rr_ovf, om_ovf, st_ovf, d_ovf, mag_ovf, az_ovf;
  logic [SQW-1:0] g_root, s_root, d_root, r_root;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_direction <= GEO_CARTESIAN;
      constant_stokes    <= 1'b1;
      viscosity          <= '0;
      stokes_number      <= '0;
      dust_size          <= '0;
      aspect_ratio       <= QW'(ONE64);
      time_step          <= '0;
      beam_radius        <= QW'(ONE64);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GEOMETRY:  geometry_direction <= geo_t'(cfg_data[1:0]);
        REG_CONST_ST:  constant_stokes    <= cfg_data[0];
        REG_VISCOSITY: viscosity          <= cfg_data;
        REG_STOKES:    stokes_number      <= cfg_data;
        REG_DUST_SIZE: dust_size          <= cfg_data;
        REG_ASPECT:    aspect_ratio       <= cfg_data;
        REG_TIME_STEP: time_step          <= cfg_data;
        REG_RADIUS:    beam_radius        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dir13   = geometry_direction inside {GEO_RADIAL, GEO_COLATITUDE};
  assign derived = (geometry_direction == GEO_RADIAL) && !constant_stokes;

  // pipeline moves unless a finished item has nowhere to go
  assign en         = !vld[LAT-1] || !out_valid || result.ready;
  assign feed.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], feed.valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      i_dl   <= feed.dust_left;
      i_dr   <= feed.dust_right;
      i_gl   <= feed.gas_left;
      i_gr   <= feed.gas_right;
      i_ch   <= feed.center_here;
      i_cb   <= feed.center_before;
      i_sb   <= feed.sound_before;
      i_sh   <= feed.sound_here;
      i_surf <= feed.surface;
    end
  end

  // dust-to-gas ratios
  ddf_div u_div_rl (.clk, .en, .a(i_dl), .b(i_gl), .q(rl_q), .ovf(rl_ovf));
  ddf_div u_div_rr (.clk, .en, .a(i_dr), .b(i_gr), .q(rr_q), .ovf(rr_ovf));

  // stage 1: dx, r^2, constant numerator, density products
  always_comb begin : stage1_c
    logic signed [32:0] dx;
    qres_t m_rr2, m_num1;
    dx     = {i_ch[31], i_ch} - {i_cb[31], i_cb};
    m_rr2  = qmul(i_ch[QW-1:0], i_ch[QW-1:0]);
    m_num1 = qmul(KQ, dust_size);
    s1_next       = '0;
    s1_next.dxneg = dx[32];
    s1_next.adx   = dx[32] ? 32'(-dx) : dx[31:0];
    s1_next.chpos = !i_ch[31] && (i_ch != '0);
    s1_next.r     = i_ch[QW-1:0];
    s1_next.surf  = i_surf;
    s1_next.rr2   = m_rr2.val;
    s1_next.num1  = m_num1.val;
    s1_next.rflag = m_rr2.sat || m_num1.sat || KQ_SAT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1_next;
      p_g <= {{(64-QW){1'b0}}, i_gl} * {{(64-QW){1'b0}}, i_gr};
      p_s <= {{(64-QW){1'b0}}, i_sb} * {{(64-QW){1'b0}}, i_sh};
      p_d <= {{(64-QW){1'b0}}, i_dl} * {{(64-QW){1'b0}}, i_dr};
    end
  end

  // geometric means of gas density, sound speed and dust density
  ddf_sqrt u_sqrt_g (.clk, .en, .rad(p_g), .root(g_root));
  ddf_sqrt u_sqrt_s (.clk, .en, .rad(p_s), .root(s_root));
  ddf_sqrt u_sqrt_d (.clk, .en, .rad(p_d), .root(d_root));

  // stage 2: r^3
  always_comb begin : stage2_c
    qres_t m;
    m = qmul(s1.rr2, s1.r);
    s2_next       = s1;
    s2_next.r3    = m.val;
    s2_next.rflag = s1.rflag || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s2 <= s2_next;
  end

  // r^1.5
  ddf_sqrt u_sqrt_r (.clk, .en, .rad(64'(s2.r3) << QS_SH), .root(r_root));

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV - 2)) u_dly_a (
    .clk, .en, .d(s2), .q(s32)
  );

  // ratio difference and flux sign
  always_comb begin : stage33_c
    logic [31:0] diff;
    diff = {1'b0, rr_q} - {1'b0, rl_q};
    s33_next       = s32;
    s33_next.adiff = diff[31] ? QW'(-diff) : diff[QW-1:0];
    s33_next.neg   = (!diff[31] && (diff != '0)) == !s32.dxneg;
    s33_next.flag  = s32.flag || rl_ovf || rr_ovf;
  end

  always_ff @(posedge clk) begin
    if (en) s33 <= s33_next;
  end

  // limiter cap and g*r
  always_comb begin : stage34_c
    qres_t c, m;
    c = qclamp((64'(s_root) * 64'(d_root)) >> FRAC_BITS);
    m = qmul(g_root[QW-1:0], s33.r);
    s34_next       = s33;
    s34_next.g     = g_root[QW-1:0];
    s34_next.cap   = c.val;
    s34_next.flag  = s33.flag || c.sat;
    s34_next.den1  = m.val;
    s34_next.rflag = s33.rflag || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s34 <= s34_next;
  end

  // clamped r^1.5 and Stokes denominator
  always_comb begin : stage35_c
    qres_t c, m;
    c = qclamp({32'b0, r_root} << QS_UP);
    m = qmul(s34.den1, aspect_ratio);
    s35_next       = s34;
    s35_next.sqc   = c.val;
    s35_next.den   = m.val;
    s35_next.rflag = s34.rflag || c.sat || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s35 <= s35_next;
  end

  // keplerian frequency
  ddf_div u_div_om (.clk, .en, .a(QW'(ONE64)), .b(s35.sqc), .q(om_q), .ovf(om_ovf));

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV)) u_dly_b (
    .clk, .en, .d(s35), .q(s67)
  );

  // Stokes numerator
  always_comb begin : stage68_c
    qres_t m;
    m = qmul(s67.num1, om_q);
    s68_next       = s67;
    s68_next.num   = m.val;
    s68_next.rflag = s67.rflag || om_ovf || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s68 <= s68_next;
  end

  ddf_div u_div_st (.clk, .en, .a(s68.num), .b(s68.den), .q(st_q), .ovf(st_ovf));

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV)) u_dly_c (
    .clk, .en, .d(s68), .q(s100)
  );

  // Stokes number select and St^2
  always_comb begin : stage101_c
    logic [QW-1:0] st;
    logic          dflag;
    qres_t         m;
    if (derived) begin
      st    = s100.chpos ? st_q : MAXQ;
      dflag = !s100.chpos || s100.rflag || st_ovf;
    end else begin
      st    = stokes_number;
      dflag = 1'b0;
    end
    m = qmul(st, st);
    s101_next      = s100;
    s101_next.st2  = m.val;
    s101_next.flag = s100.flag || (dir13 && (dflag || m.sat));
  end

  always_ff @(posedge clk) begin
    if (en) s101 <= s101_next;
  end

  // 1 + St^2
  always_comb begin : stage102_c
    qres_t c;
    c = qclamp(64'(s101.st2) + ONE64);
    s102_next      = s101;
    s102_next.dden = c.val;
    s102_next.flag = s101.flag || (dir13 && c.sat);
  end

  always_ff @(posedge clk) begin
    if (en) s102 <= s102_next;
  end

  ddf_div u_div_d (.clk, .en, .a(viscosity), .b(s102.dden), .q(d_q), .ovf(d_ovf));

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV)) u_dly_d (
    .clk, .en, .d(s102), .q(s134)
  );

  // D * g
  always_comb begin : stage135_c
    logic [QW-1:0] dsel;
    qres_t         m;
    dsel = dir13 ? d_q : viscosity;
    m    = qmul(dsel, s134.g);
    s135_next      = s134;
    s135_next.dg   = m.val;
    s135_next.flag = s134.flag || (dir13 && d_ovf) || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s135 <= s135_next;
  end

  // times ratio gradient numerator
  always_comb begin : stage136_c
    qres_t m;
    m = qmul(s135.dg, s135.adiff);
    s136_next      = s135;
    s136_next.dga  = m.val;
    s136_next.flag = s135.flag || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s136 <= s136_next;
  end

  ddf_div #(.BW(32)) u_div_mag (
    .clk, .en, .a(s136.dga), .b(s136.adx), .q(mag_q), .ovf(mag_ovf)
  );

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV)) u_dly_e (
    .clk, .en, .d(s136), .q(s168)
  );

  // sound-speed limiter
  always_comb begin : stage169_c
    s169_next      = s168;
    s169_next.lim  = (mag_q > s168.cap) ? s168.cap : mag_q;
    s169_next.flag = s168.flag || mag_ovf;
  end

  always_ff @(posedge clk) begin
    if (en) s169 <= s169_next;
  end

  ddf_div u_div_az (.clk, .en, .a(s169.lim), .b(beam_radius), .q(az_q), .ovf(az_ovf));

  ddf_delay #(.W($bits(side_t)), .N(LAT_DIV)) u_dly_f (
    .clk, .en, .d(s169), .q(s201)
  );

  // azimuthal select, times surface
  always_comb begin : stage202_c
    logic          az;
    logic [QW-1:0] asel;
    qres_t         m;
    az   = geometry_direction == GEO_AZIMUTHAL;
    asel = az ? az_q : s201.lim;
    m    = qmul(asel, s201.surf);
    s202_next      = s201;
    s202_next.m1   = m.val;
    s202_next.flag = s201.flag || (az && az_ovf) || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s202 <= s202_next;
  end

  // times time step
  always_comb begin : stage203_c
    qres_t m;
    m = qmul(s202.m1, time_step);
    s203_next      = s202;
    s203_next.m2   = m.val;
    s203_next.flag = s202.flag || m.sat;
  end

  always_ff @(posedge clk) begin
    if (en) s203 <= s203_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[LAT-1]) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAT-1]) begin
      out_flux <= s203.neg ? -{1'b0, s203.m2} : {1'b0, s203.m2};
      out_sat  <= s203.flag;
    end
  end

  assign result.valid          = out_valid;
  assign result.diffusion_flux = out_flux;
  assign result.saturated      = out_sat;

  // a finished item held behind a stalled output blocks new items
  a_hold_blocks_feed: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-1] && out_valid && !result.ready |-> !feed.ready)
    else $error("feed accepted while pipeline is blocked");

  // a result only appears out of a valid last stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[LAT-1]))
    else $error("result raised without a finished item");

  // reset empties the pipeline and output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && (vld == '0))
    else $error("state not cleared by reset");

endmodule

// ===== rtl/core/ddf_delay.sv =====
// ddf_delay: enable-gated shift line that keeps side data aligned with the
// arithmetic units. No package dependency.
module ddf_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [N];

  // shift one stage per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < N; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign q = pipe[N-1];

endmodule

// ===== rtl/core/ddf_div.sv =====
// ddf_div: pipelined saturating Q quotient floor(a * 2^FRAC_BITS / b),
// one quotient bit per stage. Depends on ddf_pkg.
module ddf_div #(
  parameter int BW = 31
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ddf_pkg::QW-1:0] a,
  input  logic [BW-1:0]          b,
  output logic [ddf_pkg::QW-1:0] q,
  output logic                   ovf
);
  import ddf_pkg::*;

  localparam int NW = QW + FRAC_BITS;
  localparam int CW = (NW > BW + QW) ? NW : BW + QW;

  logic [NW-1:0] num;
  logic [CW-1:0] num_x;
  logic [CW-1:0] lim_x;
  logic          ovf0;

  logic [BW-1:0] rem_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [BW-1:0] b_q   [QW+1];
  logic          ovf_q [QW+1];

  logic [BW:0]   trial  [QW];
  logic          take   [QW];
  logic [BW-1:0] rem_next [QW];
  logic [QW-1:0] quo_next [QW];

  // overflow (and zero divisor) when the quotient reaches 2^QW
  assign num   = {a, {FRAC_BITS{1'b0}}};
  assign num_x = CW'(num);
  assign lim_x = CW'({b, {QW{1'b0}}});
  assign ovf0  = num_x >= lim_x;

  // restoring step per stage
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s]    = {rem_q[s], lo_q[s][QW-1]};
      take[s]     = trial[s] >= {1'b0, b_q[s]};
      rem_next[s] = take[s] ? BW'(trial[s] - {1'b0, b_q[s]}) : trial[s][BW-1:0];
      quo_next[s] = {quo_q[s][QW-2:0], take[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= BW'(num >> QW);
      lo_q[0]  <= num[QW-1:0];
      quo_q[0] <= '0;
      b_q[0]   <= b;
      ovf_q[0] <= ovf0;
      for (int s = 0; s < QW; s++) begin
        rem_q[s+1] <= rem_next[s];
        lo_q[s+1]  <= {lo_q[s][QW-2:0], 1'b0};
        quo_q[s+1] <= quo_next[s];
        b_q[s+1]   <= b_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign ovf = ovf_q[QW];
  assign q   = ovf_q[QW] ? MAXQ : quo_q[QW];

endmodule

// ===== rtl/core/ddf_sqrt.sv =====
// ddf_sqrt: pipelined integer square root of a 64-bit radicand, one root bit
// per stage. Depends on ddf_pkg.
module ddf_sqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [63:0]             rad,
  output logic [ddf_pkg::SQW-1:0] root
);
  import ddf_pkg::*;

  localparam int RW = SQW + 4;

  logic [RW-1:0]  rem_q [SQW];
  logic [SQW-1:0] res_q [SQW];
  logic [63:0]    rad_q [SQW];

  logic [RW-1:0]  rem_src [SQW];
  logic [SQW-1:0] res_src [SQW];
  logic [63:0]    rad_src [SQW];
  logic [RW-1:0]  shifted [SQW];
  logic [RW-1:0]  trial   [SQW];
  logic           take    [SQW];
  logic [RW-1:0]  rem_next [SQW];
  logic [SQW-1:0] res_next [SQW];

  // bring down two radicand bits, try root*4+1
  always_comb begin
    for (int s = 0; s < SQW; s++) begin
      if (s == 0) begin
        rem_src[s] = '0;
        res_src[s] = '0;
        rad_src[s] = rad;
      end else begin
        rem_src[s] = rem_q[s-1];
        res_src[s] = res_q[s-1];
        rad_src[s] = rad_q[s-1];
      end
      shifted[s]  = {rem_src[s][RW-3:0], rad_src[s][63:62]};
      trial[s]    = RW'({res_src[s], 2'b01});
      take[s]     = shifted[s] >= trial[s];
      rem_next[s] = take[s] ? shifted[s] - trial[s] : shifted[s];
      res_next[s] = {res_src[s][SQW-2:0], take[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQW; s++) begin
        rem_q[s] <= rem_next[s];
        res_q[s] <= res_next[s];
        rad_q[s] <= {rad_src[s][61:0], 2'b00};
      end
    end
  end

  assign root = res_q[SQW-1];

endmodule
